// ===== design/rational_accumulator_alu_top_macros.svh =====
// Assertion macros for the rational accumulator
`ifndef RATIONAL_ACCUMULATOR_ALU_TOP_MACROS_SVH
`define RATIONAL_ACCUMULATOR_ALU_TOP_MACROS_SVH

// Implication checked on every edge outside reset
`define RA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset
`define RA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/rat_pkg.sv =====
`default_nettype none
package rat_pkg;
    localparam int unsigned WORD_BITS_DEF = 32;
    localparam int unsigned OP_BITS       = 32;
    localparam int unsigned MAG_BITS      = 64;

    // operation kinds
    localparam logic [2:0] KIND_LOAD = 3'd0;
    localparam logic [2:0] KIND_ADD  = 3'd1;
    localparam logic [2:0] KIND_SUB  = 3'd2;
    localparam logic [2:0] KIND_MUL  = 3'd3;
    localparam logic [2:0] KIND_DIV  = 3'd4;
    localparam logic [2:0] KIND_INV  = 3'd5;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    typedef logic [MAG_BITS-1:0] t_mag;
endpackage
`default_nettype wire

// ===== design/rational_accumulator_alu_top.sv =====
// Channel  | Signals                                          | Direction
// ---------+--------------------------------------------------+----------
// request  | i_valid, o_stall, i_kind, i_operand_num/den      | in
// result   | o_valid, i_stall, o_result_num/den, o_status     | out
//
// One transaction at a time. A zero denominator, a divide by zero, an invert of
// zero or an unused kind goes straight to the output state; any other kind runs
// on the 64-bit add/subtract/shift datapath: multiplies run shift-and-add, each
// routed in S_COMB (none for load/invert, two for mul/div, three for add/sub),
// binary gcd runs one step a cycle, and the two quotients run restoring
// division.
// Reset (synchronous, active low) sets the accumulator to 0/1 and goes idle.
// The finished result sits in an output register; the block accepts the
// next request as soon as that result is taken or while it is offered
// and not stalled.
`default_nettype none
`include "rational_accumulator_alu_top_macros.svh"
module rational_accumulator_alu_top #(
    parameter int unsigned WORD_BITS = rat_pkg::WORD_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_kind,
    input  wire logic signed [31:0] i_operand_num,
    input  wire logic signed [31:0] i_operand_den,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic signed [31:0] o_result_num,
    output logic [30:0]      o_result_den,
    output logic [1:0]       o_status
);
    localparam int unsigned MB = rat_pkg::MAG_BITS;

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;
    localparam logic [3:0] S_COMB  = 4'd2;
    localparam logic [3:0] S_GPRE  = 4'd3;
    localparam logic [3:0] S_GTWO  = 4'd4;
    localparam logic [3:0] S_GAOD  = 4'd5;
    localparam logic [3:0] S_GLOOP = 4'd6;
    localparam logic [3:0] S_GFIN  = 4'd7;
    localparam logic [3:0] S_DIV   = 4'd8;
    localparam logic [3:0] S_CHK   = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    // multiply job selectors
    localparam logic [1:0] M_AD = 2'd0;
    localparam logic [1:0] M_CB = 2'd1;
    localparam logic [1:0] M_BD = 2'd2;
    localparam logic [1:0] M_AC = 2'd3;

    logic [3:0]  r_state;
    logic [WORD_BITS-1:0] r_acc_num;
    logic [WORD_BITS-2:0] r_acc_den;
    logic [2:0]  r_kind;
    logic        r_cneg, r_dneg;
    logic [31:0] r_cmag, r_dmag;
    logic [1:0]  r_mjob;
    logic [5:0]  r_cnt;
    rat_pkg::t_mag r_p0, r_p1, r_p2;     // products / operands
    logic        r_n0, r_n1;             // signs of p0, p1
    rat_pkg::t_mag r_nm, r_dm;           // numerator/denominator magnitudes
    logic        r_nneg, r_dneg2;
    rat_pkg::t_mag r_g;
    logic [6:0]  r_gk;
    logic        r_dsel;                 // 0 dividing numerator, 1 denominator
    rat_pkg::t_mag r_rem, r_quo;
    rat_pkg::t_mag r_qn;
    logic        r_ovalid;
    logic signed [31:0] r_onum;
    logic [30:0] r_oden;
    logic [1:0]  r_ost;

    logic [31:0] mc_a, mc_b;
    logic        busy;

    // helpers
    logic        in_acc;
    logic [31:0] acc_amag, den_ext;
    logic        acc_neg;
    rat_pkg::t_mag add_sum, sub_ab, sub_ba, rem_sh, rem_try;
    logic        ab_ge, rem_ge;
    rat_pkg::t_mag half, nm_f, dm_f;
    logic        neg_f;

    assign busy    = (r_state != S_IDLE);
    assign in_acc  = i_valid && !o_stall;
    assign o_stall = busy || (r_ovalid && i_stall);
    assign o_valid = r_ovalid;
    assign o_result_num = r_onum;
    assign o_result_den = r_oden;
    assign o_status     = r_ost;

    assign acc_neg  = r_acc_num[WORD_BITS-1];
    assign acc_amag = 32'(acc_neg ? -{{(33-WORD_BITS){1'b1}}, r_acc_num}
                                  : {{(33-WORD_BITS){1'b0}}, r_acc_num});
    assign den_ext  = 32'(r_acc_den);

    // multiplier operand select (a,d), (c,b), (a,c), (b,d)
    always_comb begin
        unique case (r_mjob)
            M_AD:    begin mc_a = acc_amag; mc_b = r_dmag; end
            M_CB:    begin mc_a = r_cmag;   mc_b = den_ext; end
            M_AC:    begin mc_a = acc_amag; mc_b = r_cmag; end
            default: begin mc_a = den_ext;  mc_b = r_dmag; end
        endcase
    end

    // shared add/compare unit
    assign ab_ge   = (r_p0 >= r_p1);
    assign sub_ab  = r_p0 - r_p1;
    assign sub_ba  = r_p1 - r_p0;
    assign add_sum = r_p0 + r_p1;
    assign rem_sh  = {r_rem[MB-2:0], r_qn[MB-1]};
    assign rem_ge  = (rem_sh >= r_g);
    assign rem_try = rem_sh - r_g;

    assign half  = rat_pkg::t_mag'(1) << (WORD_BITS - 1);
    assign nm_f  = r_nm;
    assign dm_f  = (r_nm == '0) ? rat_pkg::t_mag'(1) : r_dm;
    assign neg_f = (r_nneg != r_dneg2) && (r_nm != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_acc_num <= '0;
            r_acc_den <= (WORD_BITS-1)'(1);
            r_ovalid  <= 1'b0;
            r_mjob    <= M_AD;
        end else begin
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_kind <= i_kind;
                        r_cneg <= i_operand_num[31];
                        r_cmag <= i_operand_num[31] ? -i_operand_num : i_operand_num;
                        r_dneg <= i_operand_den[31];
                        r_dmag <= i_operand_den[31] ? -i_operand_den : i_operand_den;
                        r_cnt  <= '0;
                        r_p2   <= '0;
                        // early outs, then the first multiply job of each kind that multiplies
                        priority if ((i_kind <= rat_pkg::KIND_DIV && i_operand_den == '0) ||
                            (i_kind == rat_pkg::KIND_DIV && i_operand_num == '0) ||
                            (i_kind == rat_pkg::KIND_INV && r_acc_num == '0)) begin
                            r_ost   <= rat_pkg::ST_ZERO;
                            r_state <= S_OUT;
                        end else if (i_kind > rat_pkg::KIND_INV) begin
                            r_ost   <= rat_pkg::ST_OK;
                            r_state <= S_OUT;
                        end else if (i_kind == rat_pkg::KIND_LOAD ||
                                     i_kind == rat_pkg::KIND_INV) begin
                            r_state <= S_COMB;
                        end else if (i_kind == rat_pkg::KIND_MUL) begin
                            r_mjob  <= M_AC;
                            r_state <= S_MUL;
                        end else begin
                            r_mjob  <= M_AD;
                            r_state <= S_MUL;
                        end
                    end
                end
                // shift-and-add multiply, one bit a cycle into r_p2
                S_MUL: begin
                    if (mc_b[r_cnt[4:0]])
                        r_p2 <= r_p2 + (rat_pkg::t_mag'(mc_a) << r_cnt[4:0]);
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd31) begin
                        r_cnt <= '0;
                        r_state <= S_COMB;
                    end
                end
                // route products; start next multiply or move to combine
                S_COMB: begin
                    r_state <= S_MUL;
                    r_p2 <= '0;
                    unique case (r_kind)
                        rat_pkg::KIND_LOAD: begin
                            r_nm <= 64'(r_cmag); r_nneg <= r_cneg;
                            r_dm <= 64'(r_dmag); r_dneg2 <= r_dneg;
                            r_state <= S_GPRE;
                        end
                        rat_pkg::KIND_INV: begin
                            r_nm <= 64'(den_ext); r_nneg <= 1'b0;
                            r_dm <= 64'(acc_amag); r_dneg2 <= acc_neg;
                            r_state <= S_GPRE;
                        end
                        rat_pkg::KIND_MUL, rat_pkg::KIND_DIV: begin
                            if (r_mjob == M_AC || r_mjob == M_AD) begin
                                // numerator: a*c (mul) or a*d (div)
                                r_nm   <= r_p2;
                                r_nneg <= acc_neg != ((r_kind == rat_pkg::KIND_MUL)
                                                      ? r_cneg : r_dneg);
                                r_mjob <= (r_kind == rat_pkg::KIND_MUL) ? M_BD : M_CB;
                            end else begin
                                // denominator: b*d (mul) or b*c (div)
                                r_dm   <= r_p2;
                                r_dneg2 <= (r_kind == rat_pkg::KIND_MUL) ? r_dneg
                                                                         : r_cneg;
                                r_state <= S_GPRE;
                            end
                        end
                        default: begin
                            // add / subtract: p0=a*d, p1=c*b, then b*d
                            if (r_mjob == M_AD) begin
                                r_p0 <= r_p2; r_n0 <= acc_neg != r_dneg;
                                r_mjob <= M_CB;
                            end else if (r_mjob == M_CB) begin
                                r_p1 <= r_p2;
                                r_n1 <= (r_kind == rat_pkg::KIND_SUB) ? !r_cneg : r_cneg;
                                r_mjob <= M_BD;
                            end else begin
                                r_dm <= r_p2; r_dneg2 <= r_dneg;
                                priority if (r_n0 == r_n1) begin
                                    r_nm <= add_sum; r_nneg <= r_n0;
                                end else if (ab_ge) begin
                                    r_nm <= sub_ab; r_nneg <= r_n0;
                                end else begin
                                    r_nm <= sub_ba; r_nneg <= r_n1;
                                end
                                r_state <= S_GPRE;
                            end
                        end
                    endcase
                end
                // gcd setup
                S_GPRE: begin
                    r_gk <= '0;
                    r_p0 <= r_nm;
                    r_p1 <= r_dm;
                    priority if (r_nm == '0) begin
                        r_g <= r_dm; r_state <= S_GFIN;
                    end else if (r_dm == '0) begin
                        r_g <= r_nm; r_state <= S_GFIN;
                    end else r_state <= S_GTWO;
                end
                // strip common factors of two
                S_GTWO: begin
                    if (!r_p0[0] && !r_p1[0]) begin
                        r_p0 <= r_p0 >> 1; r_p1 <= r_p1 >> 1; r_gk <= r_gk + 7'd1;
                    end else r_state <= S_GAOD;
                end
                S_GAOD: begin
                    if (!r_p0[0]) r_p0 <= r_p0 >> 1;
                    else r_state <= S_GLOOP;
                end
                // one shift or one subtract per cycle
                S_GLOOP: begin
                    priority if (!r_p1[0]) r_p1 <= r_p1 >> 1;
                    else if (ab_ge) begin
                        r_p0 <= r_p1; r_p1 <= sub_ab;
                        if (sub_ab == '0) begin
                            r_g <= r_p1 << r_gk[5:0]; r_state <= S_GFIN;
                        end
                    end else begin
                        r_p1 <= sub_ba;
                        if (sub_ba == '0) begin
                            r_g <= r_p0 << r_gk[5:0]; r_state <= S_GFIN;
                        end
                    end
                end
                S_GFIN: begin
                    r_dsel <= 1'b0; r_cnt <= '0;
                    r_rem <= '0; r_qn <= r_nm; r_quo <= '0;
                    r_state <= S_DIV;
                end
                // restoring division, one quotient bit a cycle
                S_DIV: begin
                    r_qn <= r_qn << 1;
                    r_rem <= rem_ge ? rem_try : rem_sh;
                    r_quo <= {r_quo[MB-2:0], rem_ge};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd63) begin
                        r_cnt <= '0;
                        r_rem <= '0;
                        if (!r_dsel) begin
                            r_nm <= {r_quo[MB-2:0], rem_ge};
                            r_qn <= r_dm; r_dsel <= 1'b1; r_quo <= '0;
                        end else begin
                            r_dm <= {r_quo[MB-2:0], rem_ge};
                            r_state <= S_CHK;
                        end
                    end
                end
                // range check, then store when in range
                S_CHK: begin
                    r_state <= S_OUT;
                    if (dm_f > half - 64'd1 ||
                        (neg_f ? (nm_f > half) : (nm_f > half - 64'd1))) begin
                        r_ost <= rat_pkg::ST_OVF;
                    end else begin
                        r_ost <= rat_pkg::ST_OK;
                        r_acc_num <= WORD_BITS'(neg_f ? -nm_f : nm_f);
                        r_acc_den <= (WORD_BITS-1)'(dm_f);
                    end
                end
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_onum   <= 32'(signed'(r_acc_num));
                    r_oden   <= 31'(r_acc_den);
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `RA_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, busy, o_stall)
    `RA_ASSERT_IMP(a_den_nonzero, i_clk, i_rst_n, 1'b1, r_acc_den != '0)
    `RA_ASSERT_NXT(a_out_from_state, i_clk, i_rst_n, r_state == S_OUT, r_ovalid)
endmodule
`default_nettype wire
